// File: rtl/adr_pkg.sv
package adr_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] item_value;
        logic                      item_last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic                      out_last;
        logic [COUNT_W-1:0]        distinct_count;
        logic                      overflow;
    } result_t;

    // Broadcast controls to every cell in the chain
    typedef struct packed {
        logic append;   // store key in the first free cell
        logic shift;    // move every cell one place toward the head
    } cell_ctrl_t;

endpackage

// File: rtl/adr_cell.sv
module adr_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  adr_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [adr_pkg::VALUE_W-1:0]  key,
    input  logic                                prev_valid,
    input  logic signed [adr_pkg::VALUE_W-1:0]  next_value,
    input  logic                                next_valid,
    output logic signed [adr_pkg::VALUE_W-1:0]  value,
    output logic                                valid,
    output logic                                match
);

    logic signed [adr_pkg::VALUE_W-1:0] value_reg;
    logic signed [adr_pkg::VALUE_W-1:0] value_next;
    logic                               valid_reg;
    logic                               valid_next;
    logic                               take_key;

    // cells fill in order, so the first free cell follows a used one
    assign take_key = ctrl.append && prev_valid && !valid_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (take_key)
        begin
            value_next = key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (value_reg == key);

endmodule

// File: rtl/array_duplicate_remover.sv
// Loading: one element beat per cycle, each compared against all cells at once.
// Emit: after the marked element, CAPACITY-long chain shifts out one value per cycle
// while the output is not stalled; the run emits distinct_count values.
// Input stalls during emit; the next array may start once the last value is in the
// output register. Reset (rst_n, async, active low) empties all cells and clears flags.
module array_duplicate_remover #(
    parameter int CAPACITY = adr_pkg::CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  adr_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output adr_pkg::result_t result
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {ST_LOAD, ST_EMIT} state_t;

    state_t                              state_reg;
    logic [CW-1:0]                       kept_count_reg;
    logic                                overflow_reg;
    logic                                result_valid_reg;
    adr_pkg::result_t                    result_reg;

    adr_pkg::cell_ctrl_t                 ctrl;
    logic signed [adr_pkg::VALUE_W-1:0]  cell_value [CAPACITY];
    logic [CAPACITY-1:0]                 cell_valid;
    logic [CAPACITY-1:0]                 cell_match;
    logic                                accept;
    logic                                hit;
    logic                                full;
    logic                                head_last;
    logic [CW+adr_pkg::COUNT_W-1:0]      count_ext;

    assign item_stall = (state_reg != ST_LOAD);
    assign accept     = item_valid && !item_stall;
    assign hit        = |cell_match;
    assign full       = cell_valid[CAPACITY-1];
    assign head_last  = !cell_valid[1];
    assign count_ext  = {{adr_pkg::COUNT_W{1'b0}}, kept_count_reg};

    always_comb
    begin
        ctrl.append = accept && !hit && !full;
        ctrl.shift  = (state_reg == ST_EMIT) && (!result_valid_reg || !result_stall);
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic                               prev_v;
            logic signed [adr_pkg::VALUE_W-1:0] nxt_value;
            logic                               nxt_valid;

            if (g == 0)
            begin : g_head
                assign prev_v = 1'b1;
            end
            else
            begin : g_body
                assign prev_v = cell_valid[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign nxt_value = '0;
                assign nxt_valid = 1'b0;
            end
            else
            begin : g_link
                assign nxt_value = cell_value[g+1];
                assign nxt_valid = cell_valid[g+1];
            end

            adr_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .key        (item.item_value),
                .prev_valid (prev_v),
                .next_value (nxt_value),
                .next_valid (nxt_valid),
                .value      (cell_value[g]),
                .valid      (cell_valid[g]),
                .match      (cell_match[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            kept_count_reg   <= '0;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (ctrl.append)
                        begin
                            kept_count_reg <= kept_count_reg + CW'(1);
                        end
                        if (!hit && full)
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (item.item_last)
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (ctrl.shift)
                    begin
                        result_valid_reg <= 1'b1;
                        if (head_last)
                        begin
                            state_reg      <= ST_LOAD;
                            kept_count_reg <= '0;
                            overflow_reg   <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // payload of the output beat, loaded as the head cell shifts out
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            result_reg.out_value      <= cell_value[0];
            result_reg.out_last       <= head_last;
            result_reg.distinct_count <= count_ext[adr_pkg::COUNT_W-1:0];
            result_reg.overflow       <= overflow_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
